@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define OEF_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define OEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/oef_pkg.sv @@
// Types and constants of the One Euro adaptive filter.
`timescale 1ns / 1ps

package oef_pkg;

    localparam int DT_FRAC_BITS = 24;

    localparam logic [47:0] CUTOFF_FLOOR = 48'd655;
    localparam logic [47:0] CUTOFF_CAP   = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] DERIV_CAP    = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [31:0] TWO_PI_Q28   = 32'd1686629713;
    localparam logic [63:0] ONE_Q24      = 64'h0000_0000_0100_0000;
    localparam logic [63:0] ONE_Q48      = 64'h0001_0000_0000_0000;
    localparam logic [24:0] ALPHA_ONE    = 25'h100_0000;

    localparam logic [1:0] REG_BASE_CUTOFF  = 2'd0;
    localparam logic [1:0] REG_SPEED_COEF   = 2'd1;
    localparam logic [1:0] REG_DERIV_CUTOFF = 2'd2;

    typedef enum logic [10:0] {
        ST_IDLE       = 11'b000_0000_0001,
        ST_DERIV_DIV  = 11'b000_0000_0010,
        ST_ALPHA_LOAD = 11'b000_0000_0100,
        ST_ALPHA_M1   = 11'b000_0000_1000,
        ST_ALPHA_M2   = 11'b000_0001_0000,
        ST_ALPHA_DIV  = 11'b000_0010_0000,
        ST_BLEND_LOAD = 11'b000_0100_0000,
        ST_BLEND_MUL  = 11'b000_1000_0000,
        ST_BETA_LOAD  = 11'b001_0000_0000,
        ST_BETA_MUL   = 11'b010_0000_0000,
        ST_RESULT     = 11'b100_0000_0000
    } oef_state_t;

endpackage

@@ rtl/core/one_euro_adaptive_filter.sv @@
// One Euro adaptive low-pass filter with a shared serial multiplier and divider.
`timescale 1ns / 1ps
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------
//  input     | in_valid / in_ready    | sample_value, time_step
//  output    | out_valid / out_ready  | filtered_value
//  config    | cfg_write              | cfg_index, cfg_data
//
// The first transfer after reset passes through and its result is offered in the
// next cycle. Every later transfer keeps the block busy until its result is
// offered: a 64-step division for the raw derivative, then for the derivative and
// again for the sample a blend factor (a load state, two 32-step multiplications
// and a 64-step division) and a blend (a load state and a 32-step multiplication),
// with a speed multiplication (a load state and 32 steps) between the two passes,
// all on the bit-serial multiplier and restoring divider. The block takes one
// transfer at a time and is ready again in the cycle after its result is taken;
// reset is asynchronous, active low.

module one_euro_adaptive_filter
    import oef_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sample_value,
    input  logic [24:0]        time_step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] filtered_value,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // Configuration registers.
    logic [31:0] base_cutoff_reg;
    logic [31:0] beta_reg;
    logic [31:0] dcut_reg;

    // Filter state.
    logic        seeded_reg;
    logic [31:0] smooth_reg;
    logic [31:0] prev_reg;
    logic [47:0] sderiv_reg;

    // Working registers of the current transfer.
    oef_state_t  state_reg;
    logic [31:0] sample_reg;
    logic [24:0] dt_reg;
    logic [47:0] draw_reg;
    logic [47:0] fc_reg;
    logic [24:0] alpha_reg;
    logic        pass_reg;   // low while smoothing the derivative, high for the sample
    logic        neg_reg;
    logic [31:0] out_reg;

    // Shared shift-add multiplier: product accumulates in the upper 64 bits
    // while the multiplier bits shift out at the bottom.
    logic [63:0] mul_a_reg;
    logic [95:0] mul_p_reg;

    // Shared restoring divider, one quotient bit per cycle.
    logic [63:0] div_n_reg;
    logic [63:0] div_r_reg;
    logic [63:0] div_d_reg;
    logic [63:0] div_q_reg;

    logic [5:0]  cnt_reg;

    logic [64:0] mul_sum;
    logic [95:0] mul_prod;
    logic [63:0] rem_sh;
    logic        rem_ge;
    logic [63:0] rem_new;
    logic [63:0] div_q_new;

    logic [24:0] dt_in;
    logic [32:0] in_diff;
    logic [32:0] in_mag;

    logic [47:0] q_sat;
    logic [47:0] fc_pick;
    logic [47:0] fc_clamp;
    logic [48:0] cur49;
    logic [48:0] tgt49;
    logic [48:0] diff49;
    logic [48:0] mag49;
    logic [48:0] res49;
    logic [47:0] absd;
    logic [79:0] beta_prod;
    logic [47:0] beta_sat;
    logic [48:0] fc_sum;

    always_comb
    begin
        mul_sum  = {1'b0, mul_p_reg[95:32]} + (mul_p_reg[0] ? {1'b0, mul_a_reg} : 65'd0);
        mul_prod = {mul_sum, mul_p_reg[31:1]};

        rem_sh    = {div_r_reg[62:0], div_n_reg[63]};
        rem_ge    = (rem_sh >= div_d_reg);
        rem_new   = rem_ge ? (rem_sh - div_d_reg) : rem_sh;
        div_q_new = {div_q_reg[62:0], rem_ge};

        // A zero time step counts as one unit.
        dt_in   = (time_step == 25'd0) ? 25'd1 : time_step;
        in_diff = {sample_value[31], sample_value} - {prev_reg[31], prev_reg};
        in_mag  = in_diff[32] ? (33'd0 - in_diff) : in_diff;

        q_sat = (div_q_new > DERIV_CAP) ? DERIV_CAP[47:0] : div_q_new[47:0];

        fc_pick  = pass_reg ? fc_reg : {16'd0, dcut_reg};
        fc_clamp = (fc_pick < CUTOFF_FLOOR) ? CUTOFF_FLOOR : fc_pick;

        cur49 = pass_reg ? {{17{smooth_reg[31]}}, smooth_reg} : {sderiv_reg[47], sderiv_reg};
        tgt49 = pass_reg ? {{17{sample_reg[31]}}, sample_reg} : {draw_reg[47], draw_reg};
        diff49 = tgt49 - cur49;
        mag49  = diff49[48] ? (49'd0 - diff49) : diff49;
        // The step toward the target truncates toward zero.
        res49  = neg_reg ? (cur49 - mul_prod[72:24]) : (cur49 + mul_prod[72:24]);

        absd = sderiv_reg[47] ? (48'd0 - sderiv_reg) : sderiv_reg;

        beta_prod = mul_prod[95:16];
        beta_sat  = (beta_prod[79:48] != 32'd0) ? CUTOFF_CAP : beta_prod[47:0];
        fc_sum    = {1'b0, beta_sat} + {17'd0, base_cutoff_reg};
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = (state_reg == ST_RESULT);
    assign filtered_value = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cutoff_reg <= 32'd65536;
            beta_reg        <= 32'd459;
            dcut_reg        <= 32'd65536;
            seeded_reg      <= 1'b0;
            smooth_reg      <= '0;
            prev_reg        <= '0;
            sderiv_reg      <= '0;
            state_reg       <= ST_IDLE;
            sample_reg      <= '0;
            dt_reg          <= '0;
            draw_reg        <= '0;
            fc_reg          <= '0;
            alpha_reg       <= '0;
            pass_reg        <= 1'b0;
            neg_reg         <= 1'b0;
            out_reg         <= '0;
            mul_a_reg       <= '0;
            mul_p_reg       <= '0;
            div_n_reg       <= '0;
            div_r_reg       <= '0;
            div_d_reg       <= '0;
            div_q_reg       <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_BASE_CUTOFF:  base_cutoff_reg <= cfg_data;
                    REG_SPEED_COEF:   beta_reg        <= cfg_data;
                    REG_DERIV_CUTOFF: dcut_reg        <= cfg_data;
                    default:          ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        sample_reg <= sample_value;
                        dt_reg     <= dt_in;
                        if (!seeded_reg)
                        begin
                            seeded_reg <= 1'b1;
                            smooth_reg <= sample_value;
                            prev_reg   <= sample_value;
                            sderiv_reg <= '0;
                            out_reg    <= sample_value;
                            state_reg  <= ST_RESULT;
                        end
                        else
                        begin
                            neg_reg   <= in_diff[32];
                            div_n_reg <= {7'd0, in_mag, 24'd0};
                            div_r_reg <= '0;
                            div_q_reg <= '0;
                            div_d_reg <= {39'd0, dt_in};
                            cnt_reg   <= 6'd63;
                            state_reg <= ST_DERIV_DIV;
                        end
                    end
                end

                ST_DERIV_DIV:
                begin
                    div_n_reg <= {div_n_reg[62:0], 1'b0};
                    div_r_reg <= rem_new;
                    div_q_reg <= div_q_new;
                    cnt_reg   <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        draw_reg  <= neg_reg ? (48'd0 - q_sat) : q_sat;
                        prev_reg  <= sample_reg;
                        pass_reg  <= 1'b0;
                        state_reg <= ST_ALPHA_LOAD;
                    end
                end

                ST_ALPHA_LOAD:
                begin
                    mul_a_reg <= {16'd0, fc_clamp};
                    mul_p_reg <= {71'd0, dt_reg};
                    cnt_reg   <= 6'd31;
                    state_reg <= ST_ALPHA_M1;
                end

                ST_ALPHA_M1:
                begin
                    mul_p_reg <= mul_prod;
                    cnt_reg   <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        // fc * dt scaled to seconds in Q24.
                        mul_a_reg <= {7'd0, mul_prod[72:16]};
                        mul_p_reg <= {64'd0, TWO_PI_Q28};
                        cnt_reg   <= 6'd31;
                        state_reg <= ST_ALPHA_M2;
                    end
                end

                ST_ALPHA_M2:
                begin
                    mul_p_reg <= mul_prod;
                    cnt_reg   <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        div_n_reg <= ONE_Q48;
                        div_r_reg <= '0;
                        div_q_reg <= '0;
                        div_d_reg <= {4'd0, mul_prod[87:28]} + ONE_Q24;
                        cnt_reg   <= 6'd63;
                        state_reg <= ST_ALPHA_DIV;
                    end
                end

                ST_ALPHA_DIV:
                begin
                    div_n_reg <= {div_n_reg[62:0], 1'b0};
                    div_r_reg <= rem_new;
                    div_q_reg <= div_q_new;
                    cnt_reg   <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        alpha_reg <= ALPHA_ONE - div_q_new[24:0];
                        state_reg <= ST_BLEND_LOAD;
                    end
                end

                ST_BLEND_LOAD:
                begin
                    neg_reg   <= diff49[48];
                    mul_a_reg <= {15'd0, mag49};
                    mul_p_reg <= {71'd0, alpha_reg};
                    cnt_reg   <= 6'd31;
                    state_reg <= ST_BLEND_MUL;
                end

                ST_BLEND_MUL:
                begin
                    mul_p_reg <= mul_prod;
                    cnt_reg   <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        if (!pass_reg)
                        begin
                            sderiv_reg <= res49[47:0];
                            state_reg  <= ST_BETA_LOAD;
                        end
                        else
                        begin
                            smooth_reg <= res49[31:0];
                            out_reg    <= res49[31:0];
                            state_reg  <= ST_RESULT;
                        end
                    end
                end

                ST_BETA_LOAD:
                begin
                    mul_a_reg <= {16'd0, absd};
                    mul_p_reg <= {64'd0, beta_reg};
                    cnt_reg   <= 6'd31;
                    state_reg <= ST_BETA_MUL;
                end

                ST_BETA_MUL:
                begin
                    mul_p_reg <= mul_prod;
                    cnt_reg   <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        // Main cutoff saturates at the 48-bit cap.
                        fc_reg    <= fc_sum[48] ? CUTOFF_CAP : fc_sum[47:0];
                        pass_reg  <= 1'b1;
                        state_reg <= ST_ALPHA_LOAD;
                    end
                end

                ST_RESULT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/oef_checker.sv @@
// Port-level assertions of the One Euro filter and their binding.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module oef_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [31:0] filtered_value,
    input logic        out_valid,
    input logic        out_ready
);

    // A held result keeps its value until it is taken.
    `OEF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(filtered_value))

    // The block never offers a result while it takes new input.
    `OEF_ASSERT_ALWAYS(a_ready_excl, clk, rst_n, !(in_ready && out_valid))

    // After an input transfer the block is busy.
    `OEF_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)

    // After an output transfer the block is ready again.
    `OEF_ASSERT_NEXT(a_idle_after_out, clk, rst_n, out_valid && out_ready, in_ready && !out_valid)

endmodule

bind one_euro_adaptive_filter oef_checker u_oef_checker (.*);

@@ tb/one_euro_adaptive_filter_test.sv @@
// Self-checking testbench for the One Euro adaptive filter.
`timescale 1ns / 1ps

module one_euro_adaptive_filter_test;
    import oef_pkg::*;

    // The run is bounded by a generous cycle count that covers each item's serial
    // computation in the block, plus sender gaps and receiver stalls.
    localparam int CYCLE_LIMIT = 6000000;
    // Number of random items in each configuration phase.
    localparam int PHASE_ITEMS = 240;
    localparam int PHASES = 8;
    // A register index past the end of the register list.
    localparam logic [1:0] REG_PAST_END = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] sample_value;
    logic [24:0]        time_step;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] filtered_value;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    one_euro_adaptive_filter u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_value   (sample_value),
        .time_step      (time_step),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_value (filtered_value),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Idle patterns: none, sender gaps, receiver stalls, both.
    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;
    idle_mode_t idle_mode;

    // Model copy of the configuration registers.
    logic [63:0] base_cutoff;
    logic [63:0] speed_coef;
    logic [63:0] deriv_cutoff;

    // Model copy of the filter state.
    logic               is_seeded;
    logic signed [63:0] smooth_val;
    logic signed [63:0] prev_sample;
    logic signed [63:0] smooth_deriv;

    // Filtered values still waiting for their output transfer, oldest first.
    logic signed [31:0] pending_filtered[$];

    int error_count;
    int cycle_count;

    // Directed rows. Only the seeding row carries a typed-in value, since the first
    // sample after reset passes straight through.
    typedef struct {
        logic signed [31:0] sample;
        logic [24:0]        dt;
        logic               typed;
        logic signed [31:0] filtered;
    } directed_row_t;

    directed_row_t directed_rows[15] = '{
        '{32'sh7FFF_FFFF, 25'd0,        1'b1, 32'sh7FFF_FFFF},
        '{32'sh8000_0000, 25'd0,        1'b0, 32'sd0},
        '{32'sh7FFF_FFFF, 25'd0,        1'b0, 32'sd0},
        '{32'sh8000_0000, 25'd1,        1'b0, 32'sd0},
        '{32'sd0,         25'd16777216, 1'b0, 32'sd0},
        '{32'sd65536,     25'h1FF_FFFF, 1'b0, 32'sd0},
        '{32'sd65536,     25'd167772,   1'b0, 32'sd0},
        '{32'sd131072,    25'd167772,   1'b0, 32'sd0},
        '{32'sd196608,    25'd167772,   1'b0, 32'sd0},
        '{-32'sd65536,    25'd16777,    1'b0, 32'sd0},
        '{32'sh5555_5555, 25'h0AA_AAAA, 1'b0, 32'sd0},
        '{32'shAAAA_AAAA, 25'h155_5555, 1'b0, 32'sd0},
        '{32'sd1,         25'd2,        1'b0, 32'sd0},
        '{-32'sd1,        25'd2,        1'b0, 32'sd0},
        '{32'sd0,         25'd1000,     1'b0, 32'sd0}
    };

    // 8 ns clock.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // floor(a * b / 2^shift), saturated at cap.
    function automatic logic [63:0] mul_shift_sat(logic [63:0] a, logic [63:0] b,
                                                  int shift, logic [63:0] cap);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod >> shift;
        if (prod > {64'd0, cap})
            return cap;
        return prod[63:0];
    endfunction

    // Blend factor in Q24 for cutoff fc (Q16.16) over dt units of 2^-24 s.
    function automatic logic [63:0] blend_factor(logic [63:0] fc, logic [63:0] dt);
        logic [63:0] m;
        logic [63:0] w;
        if (fc < {16'd0, CUTOFF_FLOOR})
            fc = {16'd0, CUTOFF_FLOOR};
        m = mul_shift_sat(fc, dt, 16 + DT_FRAC_BITS - 24, 64'd1 << 62);
        w = mul_shift_sat(m, {32'd0, TWO_PI_Q28}, 28, 64'd1 << 62);
        return ONE_Q24 - (ONE_Q48 / (w + ONE_Q24));
    endfunction

    // Moves cur toward target by alpha, truncating the step toward zero.
    function automatic logic signed [63:0] move_toward(logic signed [63:0] cur,
                                                       logic signed [63:0] target,
                                                       logic [63:0] alpha);
        logic [63:0] step;
        if (target >= cur)
        begin
            step = mul_shift_sat(target - cur, alpha, 24, '1);
            return cur + step;
        end
        step = mul_shift_sat(cur - target, alpha, 24, '1);
        return cur - step;
    endfunction

    // Raw slope between two samples, saturated to 48 bits signed.
    function automatic logic signed [63:0] raw_slope(logic signed [63:0] v,
                                                     logic signed [63:0] prev,
                                                     logic [63:0] dt);
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] quot;
        neg = v < prev;
        mag = neg ? prev - v : v - prev;
        quot = ({64'd0, mag} << DT_FRAC_BITS) / {64'd0, dt};
        if (quot > {64'd0, DERIV_CAP})
            quot = {64'd0, DERIV_CAP};
        return neg ? -$signed(quot[63:0]) : $signed(quot[63:0]);
    endfunction

    // Advances the model by one sample and returns the filtered value.
    function automatic logic signed [31:0] filter_sample(logic signed [31:0] sample,
                                                         logic [24:0] step_in);
        logic signed [63:0] v;
        logic [63:0]        dt;
        logic [63:0]        abs_deriv;
        logic [63:0]        fc;
        v = sample;
        dt = (step_in == 25'd0) ? 64'd1 : {39'd0, step_in};
        if (!is_seeded)
        begin
            is_seeded = 1'b1;
            smooth_val = v;
            prev_sample = v;
            smooth_deriv = 0;
        end
        else
        begin
            smooth_deriv = move_toward(smooth_deriv, raw_slope(v, prev_sample, dt),
                                       blend_factor(deriv_cutoff, dt));
            prev_sample = v;
            abs_deriv = (smooth_deriv < 0) ? -smooth_deriv : smooth_deriv;
            fc = mul_shift_sat(speed_coef, abs_deriv, 16, {16'd0, CUTOFF_CAP});
            fc = fc + base_cutoff;
            if (fc > {16'd0, CUTOFF_CAP})
                fc = {16'd0, CUTOFF_CAP};
            smooth_val = move_toward(smooth_val, v, blend_factor(fc, dt));
        end
        return smooth_val[31:0];
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what,
                 got, want);
        error_count++;
    endtask

    // Register write at the falling edge; the caller drops the write enable
    // after the last write of a group.
    task automatic write_register(logic [1:0] index, logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(negedge clk);
        case (index)
            REG_BASE_CUTOFF:  base_cutoff = {32'd0, data};
            REG_SPEED_COEF:   speed_coef = {32'd0, data};
            REG_DERIV_CUTOFF: deriv_cutoff = {32'd0, data};
            default: ;
        endcase
    endtask

    // Offers one sample on the input channel. The caller stands at a falling edge.
    // Only one assignment to in_valid happens per time step, so back-to-back
    // transfers keep valid high without a glitch.
    task automatic send_sample(logic signed [31:0] sample, logic [24:0] dt,
                               logic typed, logic signed [31:0] typed_value);
        int gap;
        logic signed [31:0] predicted;
        gap = 0;
        if ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 76) ||
            (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 36))
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_value <= sample;
        time_step <= dt;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = filter_sample(sample, dt);
        pending_filtered.push_back(typed ? typed_value : predicted);
        @(negedge clk);
    endtask

    // Waits until every filtered value has come back, then lets the block settle.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (pending_filtered.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Receiver stalls change at the falling edge according to the idle pattern.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (idle_mode == IDLE_RECEIVER)
            out_ready <= ($urandom_range(0, 99) >= 76);
        else if (idle_mode == IDLE_BOTH)
            out_ready <= ($urandom_range(0, 99) >= 36);
        else
            out_ready <= 1'b1;
    end

    // Output check: each transfer against the oldest pending value.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_filtered.size() == 0)
                report_mismatch("unexpected filtered_value", filtered_value, 0);
            else
            begin
                if (filtered_value !== pending_filtered[0])
                    report_mismatch("filtered_value", filtered_value,
                                    pending_filtered[0]);
                void'(pending_filtered.pop_front());
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic signed [31:0] walk;
        logic signed [31:0] sample;
        logic [24:0]        dt;
        int                 phase;
        int                 kind;

        error_count = 0;
        cycle_count = 0;
        idle_mode = IDLE_NONE;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_value = '0;
        time_step = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        base_cutoff = 64'd65536;
        speed_coef = 64'd459;
        deriv_cutoff = 64'd65536;
        is_seeded = 1'b0;
        smooth_val = 0;
        prev_sample = 0;
        smooth_deriv = 0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset configuration.
        foreach (directed_rows[i])
            send_sample(directed_rows[i].sample, directed_rows[i].dt,
                        directed_rows[i].typed, directed_rows[i].filtered);
        drain_outputs();

        for (phase = 0; phase < PHASES; phase++)
        begin
            // New settings while idle; extremes come first.
            case (phase)
                0:
                begin
                    write_register(REG_BASE_CUTOFF, 32'd65536);
                    write_register(REG_SPEED_COEF, 32'd459);
                    write_register(REG_DERIV_CUTOFF, 32'd65536);
                end
                1:
                begin
                    // Tiny cutoffs: with short steps alpha truncates to zero.
                    write_register(REG_BASE_CUTOFF, 32'd0);
                    write_register(REG_SPEED_COEF, 32'd0);
                    write_register(REG_DERIV_CUTOFF, 32'd0);
                end
                2:
                begin
                    write_register(REG_BASE_CUTOFF, 32'hFFFF_FFFF);
                    write_register(REG_SPEED_COEF, 32'hFFFF_FFFF);
                    write_register(REG_DERIV_CUTOFF, 32'hFFFF_FFFF);
                end
                default:
                begin
                    write_register(REG_BASE_CUTOFF, $urandom_range(0, 32'h0040_0000));
                    write_register(REG_SPEED_COEF,
                                   (phase == 3) ? $urandom() : $urandom_range(0, 32'h1000));
                    write_register(REG_DERIV_CUTOFF,
                                   (phase == 4) ? $urandom() : $urandom_range(0, 32'h0040_0000));
                    // An index past the register list must be ignored.
                    write_register(REG_PAST_END, $urandom());
                end
            endcase
            cfg_write <= 1'b0;
            idle_mode = idle_mode_t'(phase % 4);
            walk = $urandom();

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 70)
                begin
                    // Tracking-like stream: small moves at 90 to 1000 Hz.
                    walk = walk + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
                    sample = walk;
                    dt = 25'($urandom_range(16777, 186413));
                end
                else
                begin
                    sample = $urandom();
                    dt = 25'($urandom_range(0, 32'h01FF_FFFF));
                    if (kind < 80)
                        dt = 25'($urandom_range(0, 3));
                end
                if (phase == 1 && kind < 90)
                    dt = 25'($urandom_range(0, 40));
                send_sample(sample, dt, 1'b0, 32'sd0);
            end
            drain_outputs();
        end

        repeat (500) @(negedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
